>>> design/byte_histogram_top_k_defines.svh
// Assertion macros used by the byte histogram top level.
`ifndef BYTE_HISTOGRAM_TOP_K_DEFINES_SVH
`define BYTE_HISTOGRAM_TOP_K_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define BHT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define BHT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/bht_pkg.sv
// Shared constants, codes and helpers of the byte histogram design.
`default_nettype none

package bht_pkg;

	// Histogram geometry
	localparam int BIN_COUNT      = 256;
	localparam int BIN_IDX_W      = $clog2(BIN_COUNT);
	localparam int COUNT_BITS_DEF = 24;
	localparam int MAX_PICKS_DEF  = 64;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int TOP_W      = 7;
	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_COUNT    = 2'd1;

	// Pixel format codes
	localparam logic [1:0] FMT_GRAY = 2'd0;
	localparam logic [1:0] FMT_RGB  = 2'd1;
	localparam logic [1:0] FMT_RGBA = 2'd2;

	// Bytes per pixel; zero means nothing is counted
	function automatic logic [2:0] bht_stride(input logic [1:0] fmt);
		logic [2:0] s;
		unique case (fmt)
			FMT_GRAY: s = 3'd1;
			FMT_RGB:  s = 3'd3;
			FMT_RGBA: s = 3'd4;
			default:  s = 3'd0;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

>>> design/bht_stream_if.sv
// Stream interfaces of the byte histogram: pixel bytes in, picked values out.
`default_nettype none

interface bht_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_byte;
	logic       frame_end;

	modport source (output valid, output pixel_byte, output frame_end, input ready);
	modport sink   (input valid, input pixel_byte, input frame_end, output ready);
endinterface

interface bht_pick_if;
	logic       valid;
	logic       ready;
	logic [7:0] common_value;
	logic       final_pick;

	modport source (output valid, output common_value, output final_pick, input ready);
	modport sink   (input valid, input common_value, input final_pick, output ready);
endinterface

`default_nettype wire

>>> design/byte_histogram_top_k.sv
// Byte histogram with top-k mode selection: top level.
// Usage: raster bytes arrive on the pixel channel, one request per byte, with
// frame_end set on the last byte of a frame. The first byte of each pixel
// (stride chosen by pixel_format) is counted into a 256-bin histogram held in
// a single-port-read, single-port-write RAM. While counting, one byte is
// accepted every cycle; a read-modify-write registers the read, then writes,
// and a one-entry bypass covers back-to-back hits on the same bin.
// On the frame end byte the block stops taking input: a flush state retires
// the last count, then for each of the top_count picks (capped at MAX_PICKS)
// an argmax scan reads every bin once through the RAM read port, a tail
// state drains the compare, and a pick state loads the result register.
// Results leave on the pick channel from a single output register; when the
// receiver stalls, the next pick waits in place until the register empties.
// After the last pick the histogram is wiped at once through per-bin valid
// bits, and counting resumes while the last result may still be waiting.
// Reset: arst_n clears the histogram (valid bits), the pixel phase, the
// output register, and sets pixel_format to 0 and top_count to 1.
// Configuration is written through cfg_we / cfg_index / cfg_data by the user, only while idle; the block does no check.
`default_nettype none
`include "byte_histogram_top_k_defines.svh"

module byte_histogram_top_k #(
	parameter int COUNT_BITS = bht_pkg::COUNT_BITS_DEF,
	parameter int MAX_PICKS  = bht_pkg::MAX_PICKS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	bht_pixel_if.sink                          pixel,
	bht_pick_if.source                         result,
	input  wire logic                          cfg_we,
	input  wire logic [bht_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bht_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bht_pkg::*;

	localparam int PICK_CAP = (MAX_PICKS > 127) ? 127 : MAX_PICKS;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [BIN_IDX_W-1:0]  LAST_BIN = BIN_IDX_W'(BIN_COUNT - 1);

	typedef enum logic [2:0] {ST_RUN, ST_FLUSH, ST_SCAN, ST_TAIL, ST_PICK} state_t;

	// Control state
	state_t                 st_q;
	logic [1:0]             phase_q;
	logic [1:0]             pixel_format_q;
	logic [TOP_W-1:0]       top_count_q;
	logic [TOP_W-1:0]       rank_q;
	logic [BIN_IDX_W-1:0]   scan_idx_q;
	logic [COUNT_BITS-1:0]  best_cnt_q;
	logic [BIN_IDX_W-1:0]   best_bin_q;
	logic [BIN_COUNT-1:0]   valid_q;
	logic                   out_vld_q;
	logic [7:0]             out_value_q;
	logic                   out_final_q;

	// Pipeline registers
	logic                   cnt_vld_s1;
	logic [BIN_IDX_W-1:0]   cnt_addr_s1;
	logic                   fwd_hit_s1;
	logic [COUNT_BITS-1:0]  fwd_data_s1;
	logic                   rd_bitv_s1;
	logic [COUNT_BITS-1:0]  rd_data_s1;
	logic                   cmp_vld_s1;
	logic [BIN_IDX_W-1:0]   cmp_bin_s1;

	// Histogram RAM
	logic [COUNT_BITS-1:0]  mem [BIN_COUNT];

	logic                   pix_acc;
	logic [2:0]             stride;
	logic [2:0]             phase_inc;
	logic                   count_hit;
	logic                   rd_en;
	logic [BIN_IDX_W-1:0]   rd_addr;
	logic [COUNT_BITS-1:0]  old_cnt;
	logic                   wr_en;
	logic [COUNT_BITS-1:0]  wr_data;
	logic [COUNT_BITS-1:0]  cmp_cnt;
	logic                   better;
	logic [TOP_W-1:0]       picks;
	logic                   last_pick;
	logic                   out_free;
	logic                   pick_load;

	// Input handshake and pixel phase
	assign pixel.ready = (st_q == ST_RUN);
	assign pix_acc     = pixel.valid && pixel.ready;
	assign stride      = bht_stride(pixel_format_q);
	assign phase_inc   = {1'b0, phase_q} + 3'd1;
	assign count_hit   = pix_acc && (stride != 3'd0) && (phase_q == 2'd0);

	// RAM read port: counting byte or scan pointer
	assign rd_en   = count_hit || (st_q == ST_SCAN);
	assign rd_addr = (st_q == ST_SCAN) ? scan_idx_q : BIN_IDX_W'(pixel.pixel_byte);

	// Saturating increment with bypass of the write just made
	assign old_cnt = fwd_hit_s1 ? fwd_data_s1 : (rd_bitv_s1 ? rd_data_s1 : '0);
	assign wr_en   = cnt_vld_s1;
	assign wr_data = (old_cnt == CNT_MAX) ? old_cnt : old_cnt + 1'b1;

	// Argmax compare: strictly greater wins, so ties keep the lower bin
	assign cmp_cnt = rd_bitv_s1 ? rd_data_s1 : '0;
	assign better  = cmp_vld_s1 && (cmp_cnt > best_cnt_q);

	// Pick count and output register
	assign picks     = (top_count_q > TOP_W'(PICK_CAP)) ? TOP_W'(PICK_CAP) : top_count_q;
	assign last_pick = ((rank_q + 1'b1) == picks);
	assign out_free  = !out_vld_q || result.ready;
	assign pick_load = (st_q == ST_PICK) && out_free;

	assign result.valid        = out_vld_q;
	assign result.common_value = out_value_q;
	assign result.final_pick   = out_final_q;

	// RAM: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_addr_s1] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// Stage-one payload
	always_ff @(posedge clk) begin
		cnt_addr_s1 <= rd_addr;
		cmp_bin_s1  <= scan_idx_q;
		fwd_data_s1 <= wr_data;
		if (rd_en) begin
			rd_bitv_s1 <= valid_q[rd_addr];
		end
	end

	// Stage-one valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_s1 <= 1'b0;
			fwd_hit_s1 <= 1'b0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			cnt_vld_s1 <= count_hit;
			fwd_hit_s1 <= wr_en && count_hit && (cnt_addr_s1 == rd_addr);
			cmp_vld_s1 <= (st_q == ST_SCAN);
		end
	end

	// Sequencer, configuration, bin valid bits and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q           <= ST_RUN;
			phase_q        <= 2'd0;
			pixel_format_q <= FMT_GRAY;
			top_count_q    <= TOP_W'(1);
			rank_q         <= '0;
			scan_idx_q     <= '0;
			best_cnt_q     <= '0;
			best_bin_q     <= '0;
			valid_q        <= '0;
			out_vld_q      <= 1'b0;
			out_value_q    <= '0;
			out_final_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_PIXEL_FORMAT: pixel_format_q <= cfg_data[1:0];
					CFG_TOP_COUNT:    top_count_q    <= cfg_data[TOP_W-1:0];
					default:          ;
				endcase
			end
			// a frame with no picks wipes the bins at the flush edge instead
			if (wr_en && !((st_q == ST_FLUSH) && (picks == '0))) begin
				valid_q[cnt_addr_s1] <= 1'b1;
			end
			if (out_vld_q && result.ready && !pick_load) begin
				out_vld_q <= 1'b0;
			end
			if (better) begin
				best_cnt_q <= cmp_cnt;
				best_bin_q <= cmp_bin_s1;
			end

			unique case (st_q)
				ST_RUN: begin
					if (pix_acc) begin
						if (pixel.frame_end) begin
							phase_q <= 2'd0;
							st_q    <= ST_FLUSH;
						end else if (stride == 3'd0 || phase_inc >= stride) begin
							phase_q <= 2'd0;
						end else begin
							phase_q <= phase_inc[1:0];
						end
					end
				end
				ST_FLUSH: begin
					// last count retires at this edge
					rank_q     <= '0;
					scan_idx_q <= '0;
					best_cnt_q <= '0;
					best_bin_q <= '0;
					if (picks == '0) begin
						valid_q <= '0;
						st_q    <= ST_RUN;
					end else begin
						st_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					scan_idx_q <= scan_idx_q + 1'b1;
					if (scan_idx_q == LAST_BIN) begin
						st_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					st_q <= ST_PICK;
				end
				ST_PICK: begin
					if (out_free) begin
						out_vld_q   <= 1'b1;
						out_value_q <= 8'(best_bin_q);
						out_final_q <= last_pick;
						rank_q      <= rank_q + 1'b1;
						scan_idx_q  <= '0;
						best_cnt_q  <= '0;
						best_bin_q  <= '0;
						if (last_pick) begin
							valid_q <= '0;
							st_q    <= ST_RUN;
						end else begin
							valid_q[best_bin_q] <= 1'b0;
							st_q <= ST_SCAN;
						end
					end
				end
				default: st_q <= ST_RUN;
			endcase
		end
	end

	// Checks
	`BHT_ASSERT_NOW(a_no_count_in_scan, (st_q == ST_SCAN), !cnt_vld_s1,
		"count write pending during scan")
	`BHT_ASSERT_NOW(a_cmp_drained, (st_q == ST_PICK), !cmp_vld_s1,
		"compare stage busy at pick")
	`BHT_ASSERT_NEXT(a_pick_cleared, pick_load, !valid_q[$past(best_bin_q)],
		"picked bin not cleared")
	`BHT_ASSERT_NEXT(a_frame_wiped, pick_load && last_pick,
		(st_q == ST_RUN) && (valid_q == '0) && out_vld_q,
		"histogram not wiped after last pick")

endmodule

`default_nettype wire

>>> sim/byte_histogram_top_k_test.sv
// Self-checking testbench for byte_histogram_top_k: directed and random frames.
module byte_histogram_top_k_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bht_pkg::*;

	// Format code with no pixel stride; register indexes with no register behind them
	localparam logic [1:0] FMT_NONE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
	// Cycles to wait for the block to go quiet once every pick has arrived
	localparam int QUIET_CYCLES = 300;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} pick_rec_t;

	typedef logic [7:0] pix_q_t[$];

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bht_pixel_if pixel_ch();
	bht_pick_if pick_ch();

	byte_histogram_top_k dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel(pixel_ch),
		.result(pick_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predictor state: histogram, pixel phase and register copies
	logic [COUNT_BITS_DEF-1:0] bin_tally[BIN_COUNT];
	int unsigned pixel_phase;
	logic [1:0] fmt_reg;
	logic [TOP_W-1:0] top_reg;

	pick_rec_t picks_due[$];
	int fault_count;
	bit gaps_on;
	bit stalls_on;

	// Clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Hard stop in case the block hangs
	initial begin
		#200ms;
		$display("byte_histogram_top_k verification failed");
		$finish;
	end

	function automatic void note_fault(input string msg);
		fault_count++;
		if (fault_count <= REPORT_LIMIT) begin
			$display("%s", msg);
		end
	endfunction

	function automatic int unsigned bytes_per_pixel(input logic [1:0] fmt);
		case (fmt)
			FMT_GRAY: return 1;
			FMT_RGB:  return 3;
			FMT_RGBA: return 4;
			default:  return 0;
		endcase
	endfunction

	// Emit the top picks of the frame, then start a fresh histogram
	function automatic void rank_frame();
		int unsigned picks;
		logic [COUNT_BITS_DEF-1:0] best_cnt;
		logic [7:0] best_val;
		pick_rec_t rec;
		picks = (top_reg > MAX_PICKS_DEF) ? MAX_PICKS_DEF : top_reg;
		for (int unsigned r = 0; r < picks; r++) begin
			best_cnt = '0;
			best_val = '0;
			// strictly greater wins, so ties keep the lower value
			for (int i = 0; i < BIN_COUNT; i++) begin
				if (bin_tally[i] > best_cnt) begin
					best_cnt = bin_tally[i];
					best_val = i[7:0];
				end
			end
			bin_tally[best_val] = '0;
			rec.value = best_val;
			rec.last = (r + 1 == picks);
			picks_due.push_back(rec);
		end
		foreach (bin_tally[i]) bin_tally[i] = '0;
		pixel_phase = 0;
	endfunction

	// Count one accepted byte
	function automatic void tally_byte(input logic [7:0] pix, input logic frame_last);
		int unsigned stride;
		stride = bytes_per_pixel(fmt_reg);
		if (stride == 0) begin
			pixel_phase = 0;
		end else begin
			if (pixel_phase == 0 && bin_tally[pix] != '1) bin_tally[pix]++;
			pixel_phase = (pixel_phase + 1 >= stride) ? 0 : pixel_phase + 1;
		end
		if (frame_last) rank_frame();
	endfunction

	// Result checker
	always @(posedge clk) begin
		pick_rec_t due;
		if (arst_n && pick_ch.valid && pick_ch.ready) begin
			if (picks_due.size() == 0) begin
				note_fault($sformatf("unexpected pick: value %0d final %0b",
					pick_ch.common_value, pick_ch.final_pick));
			end else begin
				due = picks_due.pop_front();
				if (due.value !== pick_ch.common_value || due.last !== pick_ch.final_pick) begin
					note_fault($sformatf("pick mismatch: expected value %0d final %0b, got value %0d final %0b",
						due.value, due.last, pick_ch.common_value, pick_ch.final_pick));
				end
			end
		end
	end

	// Receiver: ready drops in random bursts while stalls are on
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		pick_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left != 0) begin
				stall_left--;
			end else if (stalls_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 6);
			end
			pick_ch.ready = arst_n && (stall_left == 0);
		end
	end

	// Send one byte request; returns at the falling edge after acceptance
	task automatic send_pixel(input logic [7:0] pix, input logic frame_last);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			pixel_ch.valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		pixel_ch.valid = 1'b1;
		pixel_ch.pixel_byte = pix;
		pixel_ch.frame_end = frame_last;
		@(posedge clk);
		while (!pixel_ch.ready) @(posedge clk);
		tally_byte(pix, frame_last);
		@(negedge clk);
	endtask

	task automatic send_frame(input pix_q_t pixels, input bit close);
		foreach (pixels[i]) begin
			send_pixel(pixels[i], close && (i == pixels.size() - 1));
		end
	endtask

	// Drop valid, wait for every pick, then let the block go quiet
	task automatic settle();
		pixel_ch.valid = 1'b0;
		wait (picks_due.size() == 0);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_PIXEL_FORMAT: fmt_reg = data[1:0];
			CFG_TOP_COUNT:    top_reg = data[TOP_W-1:0];
			default: ;
		endcase
	endtask

	// Reset values: gray pixels, one pick; extremes of the byte range
	task automatic test_reset_defaults();
		send_frame({8'd0, 8'd255, 8'd255}, 1'b1);
	endtask

	// Ties go to the lower value, and an empty histogram yields zero
	task automatic test_ties_and_empty();
		settle();
		write_reg(CFG_TOP_COUNT, 7'd4);
		send_frame({8'd9, 8'd3, 8'd3, 8'd9}, 1'b1);
	endtask

	// No picks at all, then check the histogram was still cleared
	task automatic test_zero_picks();
		settle();
		write_reg(CFG_TOP_COUNT, 7'd0);
		send_frame({8'd200, 8'd200}, 1'b1);
		settle();
		write_reg(CFG_TOP_COUNT, 7'd2);
		send_frame({8'd17}, 1'b1);
	endtask

	// Counts above the cap emit the cap
	task automatic test_pick_cap();
		settle();
		write_reg(CFG_TOP_COUNT, 7'd127);
		send_frame({8'h80}, 1'b1);
		settle();
		write_reg(CFG_TOP_COUNT, 7'd64);
		send_frame({8'h01}, 1'b1);
	endtask

	// Three- and four-byte pixels count only their first byte
	task automatic test_pixel_strides();
		settle();
		write_reg(CFG_PIXEL_FORMAT, {5'd0, FMT_RGB});
		write_reg(CFG_TOP_COUNT, 7'd3);
		send_frame({8'd10, 8'd20, 8'd30, 8'd10}, 1'b1);
		settle();
		write_reg(CFG_PIXEL_FORMAT, {5'd0, FMT_RGBA});
		send_frame({8'd5, 8'd6, 8'd6, 8'd6, 8'd7}, 1'b1);
	endtask

	// Unsupported format counts nothing
	task automatic test_unsupported_format();
		settle();
		write_reg(CFG_PIXEL_FORMAT, {5'd0, FMT_NONE});
		send_frame({8'd44, 8'd44}, 1'b1);
	endtask

	// Format change inside a frame: the phase runs on and wraps
	task automatic test_format_switch();
		settle();
		write_reg(CFG_PIXEL_FORMAT, {5'd0, FMT_RGBA});
		write_reg(CFG_TOP_COUNT, 7'd3);
		send_frame({8'd1, 8'd2, 8'd3}, 1'b0);
		settle();
		write_reg(CFG_PIXEL_FORMAT, {5'd0, FMT_RGB});
		send_frame({8'd4, 8'd5}, 1'b1);
	endtask

	// Writes to indexes with no register must change nothing
	task automatic test_spare_indexes();
		settle();
		write_reg(CFG_PIXEL_FORMAT, {5'd0, FMT_GRAY});
		write_reg(CFG_TOP_COUNT, 7'd2);
		write_reg(CFG_SPARE_LO, 7'h7F);
		write_reg(CFG_SPARE_HI, 7'h55);
		send_frame({8'd99, 8'd99, 8'd12}, 1'b1);
	endtask

	// Random phases of configuration and frames drawn mostly from a small palette
	task automatic test_random_traffic();
		int sent;
		int unsigned pick;
		int unsigned flen;
		logic [1:0] fmt;
		logic [TOP_W-1:0] top;
		logic [7:0] palette[6];
		logic [7:0] pix;
		sent = 0;
		while (sent < 210) begin
			settle();
			gaps_on = (sent < 170) && ($urandom_range(0, 3) != 0);
			stalls_on = (sent < 170) && ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 9);
			fmt = (pick < 3) ? FMT_GRAY : (pick < 6) ? FMT_RGB : (pick < 9) ? FMT_RGBA : FMT_NONE;
			// upper data bits are don't-care for the format register
			write_reg(CFG_PIXEL_FORMAT, {5'($urandom_range(0, 31)), fmt});
			pick = $urandom_range(0, 19);
			case (pick)
				0: top = 7'd0;
				1: top = 7'd64;
				2: top = 7'd127;
				3: top = 7'($urandom_range(65, 126));
				default: top = 7'($urandom_range(1, 6));
			endcase
			write_reg(CFG_TOP_COUNT, top);
			foreach (palette[i]) palette[i] = 8'($urandom);
			repeat ($urandom_range(1, 3)) begin
				flen = $urandom_range(1, 24);
				for (int k = 0; k < flen; k++) begin
					pix = ($urandom_range(0, 3) != 0) ? palette[$urandom_range(0, 5)] : 8'($urandom);
					send_pixel(pix, k == flen - 1);
					sent++;
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pixel_ch.valid = 1'b0;
		pixel_ch.pixel_byte = '0;
		pixel_ch.frame_end = 1'b0;
		foreach (bin_tally[i]) bin_tally[i] = '0;
		pixel_phase = 0;
		fmt_reg = FMT_GRAY;
		top_reg = 7'd1;
		fault_count = 0;
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_ties_and_empty();
		test_zero_picks();
		test_pick_cap();
		test_pixel_strides();
		test_unsupported_format();
		test_format_switch();
		test_spare_indexes();
		test_random_traffic();

		// drain, then watch for stray picks
		pixel_ch.valid = 1'b0;
		wait (picks_due.size() == 0);
		repeat (QUIET_CYCLES) @(posedge clk);
		if (fault_count == 0) begin
			$display("byte_histogram_top_k verification clean");
		end else begin
			$display("byte_histogram_top_k verification failed");
		end
		$finish;
	end

endmodule

>>> byte_histogram_top_k.f
+incdir+design
design/bht_pkg.sv
design/bht_stream_if.sv
design/byte_histogram_top_k.sv
sim/byte_histogram_top_k_test.sv
